// ===== rtl/core/hrfw_pkg.sv =====
// ----------------------------------------------------------------------------
// hrfw_pkg
// Shared types, constants and the hex digit decode for the hex record
// to flash word converter.
// ----------------------------------------------------------------------------
package hrfw_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned PosW     = 10;
  localparam int unsigned CountW   = 8;
  localparam int unsigned RecAddrW = 16;
  localparam int unsigned HoldW    = 12;
  localparam int unsigned WordIdxW = 7;
  localparam int unsigned UpperW   = 16;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned HalfW    = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [PosW-1:0]   PosMax        = 10'd1023;
  localparam logic [UpperW-1:0] UpperReset    = 16'h0800;
  localparam logic [AddrW-1:0]  OffsetReset   = 32'h0000_4000;
  localparam logic [CharW-1:0]  CharZero      = 8'd48;
  localparam logic [CharW-1:0]  CharNine      = 8'd57;
  localparam logic [CharW-1:0]  CharUpA       = 8'd65;
  localparam logic [CharW-1:0]  CharUpF       = 8'd70;
  localparam logic [CharW-1:0]  AlphaBias     = 8'd55;

  localparam logic [CfgIdxW-1:0] CfgUpperAddr   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWriteOffset = 2'd1;

  typedef struct packed {
    logic [UpperW-1:0] upper_address;
    logic [AddrW-1:0]  write_offset;
  } cfg_t;

  typedef struct packed {
    logic [AddrW-1:0] dest_addr;
    logic [HalfW-1:0] half_word;
    logic             last_of_record;
  } result_t;

  function automatic logic [3:0] hex_digit(input logic [CharW-1:0] c);
    logic [CharW-1:0] t;
    t = '0;
    if (c inside {[CharZero:CharNine]}) begin
      t = c - CharZero;
    end else if (c inside {[CharUpA:CharUpF]}) begin
      t = c - AlphaBias;
    end
    return t[3:0];
  endfunction

endpackage

// ===== rtl/core/hex_record_to_flash_words_top.sv =====
// Path: the fourth digit of a group is held in the input register, and its
//   halfword is then loaded into the result register for the output.
// Throughput: one character per cycle unless the input is stalled.
//   A held result stalls the input once the input register is also full.
// Reset: all record state clears to zero, upper address to 0x0800 and write
//   offset to 0x00004000; no results pending.
// ----------------------------------------------------------------------------
// hex_record_to_flash_words_top
// Streams hex record text and emits data halfwords with flash addresses.
// ----------------------------------------------------------------------------
module hex_record_to_flash_words_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hrfw_pkg::CharW-1:0]    character_i,
  input  logic                          record_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hrfw_pkg::AddrW-1:0]    dest_addr_o,
  output logic [hrfw_pkg::HalfW-1:0]    half_word_o,
  output logic                          last_of_record_o,
  input  logic                          cfg_we_i,
  input  logic [hrfw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hrfw_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import hrfw_pkg::*;

  cfg_t             cfg_q;
  logic             stg_valid;
  logic [CharW-1:0] stg_char;
  logic             stg_start;
  logic             out_can_take;
  logic             advance;
  logic             emit;
  result_t          result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper_address <= UpperReset;
      cfg_q.write_offset  <= OffsetReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgUpperAddr:   cfg_q.upper_address <= cfg_wdata_i[UpperW-1:0];
        CfgWriteOffset: cfg_q.write_offset  <= cfg_wdata_i[AddrW-1:0];
        default: ;
      endcase
    end
  end

  assign advance = stg_valid && out_can_take;

  hrfw_in_stage u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .character_i    (character_i),
    .record_start_i (record_start_i),
    .advance_i      (advance),
    .valid_o        (stg_valid),
    .character_o    (stg_char),
    .record_start_o (stg_start)
  );

  hrfw_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .character_i    (stg_char),
    .record_start_i (stg_start),
    .cfg_i          (cfg_q),
    .emit_o         (emit),
    .result_o       (result)
  );

  hrfw_out_stage u_out_stage (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (advance && emit),
    .result_i         (result),
    .can_take_o       (out_can_take),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .dest_addr_o      (dest_addr_o),
    .half_word_o      (half_word_o),
    .last_of_record_o (last_of_record_o)
  );

endmodule

// ===== rtl/core/hrfw_in_stage.sv =====
// ----------------------------------------------------------------------------
// hrfw_in_stage
// Input register: holds one character word until the parser takes it.
// ----------------------------------------------------------------------------
module hrfw_in_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [hrfw_pkg::CharW-1:0] character_i,
  input  logic                       record_start_i,
  input  logic                       advance_i,
  output logic                       valid_o,
  output logic [hrfw_pkg::CharW-1:0] character_o,
  output logic                       record_start_o
);
  import hrfw_pkg::*;

  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q;
  logic             start_q;
  logic             load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q  <= character_i;
      start_q <= record_start_i;
    end
  end

  assign valid_o        = valid_q;
  assign character_o    = char_q;
  assign record_start_o = start_q;

endmodule

// ===== rtl/core/hrfw_parser.sv =====
// ----------------------------------------------------------------------------
// hrfw_parser
// Record field state and per-character decode; builds one halfword result
// at the fourth digit of each data group.
// ----------------------------------------------------------------------------
module hrfw_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic [hrfw_pkg::CharW-1:0] character_i,
  input  logic                       record_start_i,
  input  hrfw_pkg::cfg_t             cfg_i,
  output logic                       emit_o,
  output hrfw_pkg::result_t          result_o
);
  import hrfw_pkg::*;

  logic [PosW-1:0]     pos_q, pos_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [RecAddrW-1:0] rec_addr_q, rec_addr_d;
  logic                is_data_q, is_data_d;
  logic [HoldW-1:0]    hold_q, hold_d;
  logic [WordIdxW-1:0] widx_q, widx_d;

  logic [PosW-1:0]     idx;
  logic [PosW-1:0]     grp_off;
  logic [3:0]          d;
  logic [WordIdxW-1:0] n_words;
  logic [AddrW-1:0]    base;

  always_comb begin
    idx        = record_start_i ? '0 : pos_q;
    pos_d      = (idx < PosMax) ? idx + 1'b1 : PosMax;
    count_d    = record_start_i ? '0 : count_q;
    rec_addr_d = record_start_i ? '0 : rec_addr_q;
    is_data_d  = record_start_i ? 1'b0 : is_data_q;
    hold_d     = record_start_i ? '0 : hold_q;
    widx_d     = record_start_i ? '0 : widx_q;
    d          = hex_digit(character_i);
    grp_off    = idx - 10'd9;
    n_words    = count_d[CountW-1:1];
    base       = {cfg_i.upper_address, rec_addr_d};
    emit_o     = 1'b0;
    result_o.dest_addr      = base + cfg_i.write_offset
                              + {{(AddrW-WordIdxW-1){1'b0}}, widx_d, 1'b0};
    result_o.half_word      = {hold_d[3:0], d, hold_d[11:8], hold_d[7:4]};
    result_o.last_of_record = ({1'b0, widx_d} + 8'd1) == {1'b0, n_words};

    if (idx == 10'd1 || idx == 10'd2) begin
      count_d = {count_d[CountW-5:0], d};
    end else if (idx >= 10'd3 && idx <= 10'd6) begin
      rec_addr_d = {rec_addr_d[RecAddrW-5:0], d};
    end else if (idx == 10'd8) begin
      is_data_d = (character_i == CharZero);
    end else if (idx >= 10'd9 && is_data_d && widx_d < n_words) begin
      case (grp_off[1:0])
        2'd0:    hold_d = {8'h00, d};
        2'd1,
        2'd2:    hold_d = {hold_d[HoldW-5:0], d};
        default: begin
          emit_o = 1'b1;
          widx_d = widx_d + 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      count_q    <= '0;
      rec_addr_q <= '0;
      is_data_q  <= 1'b0;
      hold_q     <= '0;
      widx_q     <= '0;
    end else if (advance_i) begin
      pos_q      <= pos_d;
      count_q    <= count_d;
      rec_addr_q <= rec_addr_d;
      is_data_q  <= is_data_d;
      hold_q     <= hold_d;
      widx_q     <= widx_d;
    end
  end

endmodule

// ===== rtl/core/hrfw_out_stage.sv =====
// ----------------------------------------------------------------------------
// hrfw_out_stage
// Result register with valid/ready toward the flash writer.
// ----------------------------------------------------------------------------
module hrfw_out_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  hrfw_pkg::result_t           result_i,
  output logic                        can_take_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hrfw_pkg::AddrW-1:0]  dest_addr_o,
  output logic [hrfw_pkg::HalfW-1:0]  half_word_o,
  output logic                        last_of_record_o
);
  import hrfw_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign can_take_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign dest_addr_o      = res_q.dest_addr;
  assign half_word_o      = res_q.half_word;
  assign last_of_record_o = res_q.last_of_record;

endmodule
